[rtl/core/red_eye_mask_correction_top_macros.svh]
// Assertion macros shared by the checker of the red-eye mask correction block.
// Each macro expands to one labeled concurrent assertion clocked by aclk.
`ifndef RED_EYE_MASK_CORRECTION_TOP_MACROS_SVH
`define RED_EYE_MASK_CORRECTION_TOP_MACROS_SVH

// Checked in the cycle after the antecedent, outside reset.
`define REM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rem check failed");

// Checked in the same cycle as the antecedent, outside reset.
`define REM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rem check failed");

// Checked in the cycle after the antecedent, also while reset is applied.
`define REM_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rem check failed");

`endif

[rtl/core/rem_pkg.sv]
// Package of the red-eye mask correction block: sizes, register codes and the
// control bundle passed to the morphology stages. No dependencies.
`default_nettype none

package rem_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int DIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 4 * (MAX_WIDTH + 1) + 1);

    localparam int LINE_PTR_W = COL_W;
    localparam int LINE_DEPTH = 1 << LINE_PTR_W;
    localparam int PIX_PTR_W  = $clog2(4 * (MAX_WIDTH + 1) + 1);
    localparam int PIX_DEPTH  = 1 << PIX_PTR_W;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 7;
    localparam int WIN_W  = 6;
    localparam int LVL_W  = 8;

    localparam logic [2:0] REG_REGION_WIDTH   = 3'd0;
    localparam logic [2:0] REG_REGION_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_WINDOW_X_FIRST = 3'd2;
    localparam logic [2:0] REG_WINDOW_Y_FIRST = 3'd3;
    localparam logic [2:0] REG_WINDOW_X_LAST  = 3'd4;
    localparam logic [2:0] REG_WINDOW_Y_LAST  = 3'd5;
    localparam logic [2:0] REG_RED_MINIMUM    = 3'd6;

    typedef struct packed {
        logic                 adv;
        logic [CNT_W-1:0]     t;
        logic [DIM_W-1:0]     fw;
        logic [DIM_W-1:0]     fh;
        logic [DIM_W-1:0]     fw_next;
        logic [PIX_PTR_W-1:0] wp;
        logic [PIX_PTR_W-1:0] wp_next;
    } rem_ctl_t;

endpackage

`default_nettype wire

[rtl/core/red_eye_mask_correction_top.sv]
// Top level of the red-eye mask correction block: register port, red test,
// pixel delay store, four morphology stages and the gray substitution.
// Depends on rem_pkg and rem_morph_stage.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_blue_in, s_green_in, s_red_in, s_fill
//   m_        out        m_valid / m_ready   m_blue_out, m_green_out, m_red_out, m_frame_end
//   apb       in         psel/penable/pwrite paddr, pwdata, prdata
//
// One item is taken per clock while s_ready is high; a result leaves the cycle after the
// transfer of the item that causes it, and trails pixel q by 4*W+4 further advancing items.
// The pixel delay store and four line stores are read into registers the cycle before use.
// Reset is synchronous and active low and needs no clearing pass.
// A fill item during the pixel phase is taken without advancing anything.
// s_ready drops only while a result waits and m_ready is low.
`default_nettype none

module red_eye_mask_correction_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rem_pkg::ADDR_W-1:0]   paddr,
    input  logic [rem_pkg::DATA_W-1:0]   pwdata,
    output logic [rem_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_blue_in,
    input  logic [7:0]                   s_green_in,
    input  logic [7:0]                   s_red_in,
    input  logic                         s_fill,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_blue_out,
    output logic [7:0]                   m_green_out,
    output logic [7:0]                   m_red_out,
    output logic                         m_frame_end
);

    localparam int CW = rem_pkg::CNT_W;
    localparam int DW = rem_pkg::DIM_W;
    localparam int PW = rem_pkg::PIX_PTR_W;

    logic [rem_pkg::SIZE_W-1:0] region_width_reg, region_height_reg;
    logic [rem_pkg::WIN_W-1:0]  wx_first_reg, wy_first_reg, wx_last_reg, wy_last_reg;
    logic [rem_pkg::LVL_W-1:0]  red_min_reg;

    logic [DW-1:0] fw_reg, fh_reg;
    logic [CW-1:0] fn_reg, t_reg;
    logic [CW-1:0] dm_reg [1:4];
    logic [PW-1:0] wp_reg;
    logic          out_active_reg;
    logic          m0_reg, s1_reg, s2_reg, s3_reg;
    logic [23:0]   pix_mem [rem_pkg::PIX_DEPTH];
    logic [23:0]   pix_rd_reg;
    logic          out_valid_reg;
    logic [7:0]    blue_reg, green_reg, red_reg;
    logic          frame_end_reg;

    logic          wr_en;
    logic [2:0]    reg_idx;
    logic          accept, pixel_phase, adv, first_item;
    logic [DW-1:0] fw_clamp, fh_clamp, fw_next;
    logic [CW-1:0] step, lag_next;
    logic [PW-1:0] wp_next, pix_addr;
    logic          red_hit;
    logic [12:0]   r20, g27, b27;
    logic          mask1, mask2, mask3, mask4;
    logic [rem_pkg::COL_W-1:0] col1, col2, col3, col4;
    logic [rem_pkg::ROW_W-1:0] row1, row2, row3, row4;
    logic          q_last, in_window, masked;
    logic [21:0]   luma_sum;
    logic [7:0]    luma;
    rem_pkg::rem_ctl_t ctl;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rem_pkg::REG_REGION_WIDTH:   prdata = rem_pkg::DATA_W'(region_width_reg);
            rem_pkg::REG_REGION_HEIGHT:  prdata = rem_pkg::DATA_W'(region_height_reg);
            rem_pkg::REG_WINDOW_X_FIRST: prdata = rem_pkg::DATA_W'(wx_first_reg);
            rem_pkg::REG_WINDOW_Y_FIRST: prdata = rem_pkg::DATA_W'(wy_first_reg);
            rem_pkg::REG_WINDOW_X_LAST:  prdata = rem_pkg::DATA_W'(wx_last_reg);
            rem_pkg::REG_WINDOW_Y_LAST:  prdata = rem_pkg::DATA_W'(wy_last_reg);
            rem_pkg::REG_RED_MINIMUM:    prdata = rem_pkg::DATA_W'(red_min_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_width_reg  <= rem_pkg::SIZE_W'(64);
            region_height_reg <= rem_pkg::SIZE_W'(64);
            wx_first_reg      <= '0;
            wy_first_reg      <= '0;
            wx_last_reg       <= rem_pkg::WIN_W'(63);
            wy_last_reg       <= rem_pkg::WIN_W'(63);
            red_min_reg       <= rem_pkg::LVL_W'(80);
        end else if (wr_en) begin
            unique case (reg_idx)
                rem_pkg::REG_REGION_WIDTH:   region_width_reg  <= pwdata[rem_pkg::SIZE_W-1:0];
                rem_pkg::REG_REGION_HEIGHT:  region_height_reg <= pwdata[rem_pkg::SIZE_W-1:0];
                rem_pkg::REG_WINDOW_X_FIRST: wx_first_reg      <= pwdata[rem_pkg::WIN_W-1:0];
                rem_pkg::REG_WINDOW_Y_FIRST: wy_first_reg      <= pwdata[rem_pkg::WIN_W-1:0];
                rem_pkg::REG_WINDOW_X_LAST:  wx_last_reg       <= pwdata[rem_pkg::WIN_W-1:0];
                rem_pkg::REG_WINDOW_Y_LAST:  wy_last_reg       <= pwdata[rem_pkg::WIN_W-1:0];
                rem_pkg::REG_RED_MINIMUM:    red_min_reg       <= pwdata[rem_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (region_width_reg == '0) begin
            fw_clamp = DW'(1);
        end else if (int'(region_width_reg) > rem_pkg::MAX_WIDTH) begin
            fw_clamp = DW'(rem_pkg::MAX_WIDTH);
        end else begin
            fw_clamp = DW'(region_width_reg);
        end
        if (region_height_reg == '0) begin
            fh_clamp = DW'(1);
        end else if (int'(region_height_reg) > rem_pkg::MAX_HEIGHT) begin
            fh_clamp = DW'(rem_pkg::MAX_HEIGHT);
        end else begin
            fh_clamp = DW'(region_height_reg);
        end
    end

    assign s_ready     = !out_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign first_item  = (t_reg == '0);
    assign pixel_phase = first_item || (t_reg < fn_reg);
    assign adv         = accept && !(pixel_phase && s_fill);

    assign fw_next  = (adv && first_item) ? fw_clamp : fw_reg;
    assign step     = CW'(fw_clamp) + CW'(1);
    assign lag_next = (CW'(fw_next) + CW'(1)) << 2;
    assign wp_next  = adv ? (wp_reg + PW'(1)) : wp_reg;
    assign pix_addr = wp_next - lag_next[PW-1:0];

    assign ctl.adv     = adv;
    assign ctl.t       = t_reg;
    assign ctl.fw      = fw_reg;
    assign ctl.fh      = fh_reg;
    assign ctl.fw_next = fw_next;
    assign ctl.wp      = wp_reg;
    assign ctl.wp_next = wp_next;

    assign r20 = 13'(s_red_in) * 13'd20;
    assign g27 = 13'(s_green_in) * 13'd27;
    assign b27 = 13'(s_blue_in) * 13'd27;
    assign red_hit = (s_red_in > red_min_reg) && (r20 > g27) && (r20 > b27);

    rem_morph_stage u_stage1 (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .start_prev(dm_reg[1]),
        .dilate(1'b0), .head_in(m0_reg), .mask_out(mask1), .col_out(col1), .row_out(row1)
    );

    rem_morph_stage u_stage2 (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .start_prev(dm_reg[2]),
        .dilate(1'b1), .head_in(s1_reg), .mask_out(mask2), .col_out(col2), .row_out(row2)
    );

    rem_morph_stage u_stage3 (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .start_prev(dm_reg[3]),
        .dilate(1'b1), .head_in(s2_reg), .mask_out(mask3), .col_out(col3), .row_out(row3)
    );

    rem_morph_stage u_stage4 (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .start_prev(dm_reg[4]),
        .dilate(1'b0), .head_in(s3_reg), .mask_out(mask4), .col_out(col4), .row_out(row4)
    );

    assign q_last = (DW'(col4) == (fw_reg - DW'(1))) && (DW'(row4) == (fh_reg - DW'(1)));

    assign in_window = (int'(col4) >= int'(wx_first_reg)) && (int'(col4) <= int'(wx_last_reg))
                    && (int'(row4) >= int'(wy_first_reg)) && (int'(row4) <= int'(wy_last_reg));
    assign masked = mask4 && in_window;

    assign luma_sum = 22'(pix_rd_reg[23:16]) * 22'd1868 + 22'(pix_rd_reg[15:8]) * 22'd9617
                    + 22'(pix_rd_reg[7:0]) * 22'd4899 + 22'd8192;
    assign luma = luma_sum[21:14];

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix_mem[wp_reg] <= {s_blue_in, s_green_in, s_red_in};
        end
        pix_rd_reg <= pix_mem[pix_addr];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m0_reg <= red_hit;
            s1_reg <= mask1;
            s2_reg <= mask2;
            s3_reg <= mask3;
        end
        if (adv && out_active_reg) begin
            blue_reg      <= masked ? luma : pix_rd_reg[23:16];
            green_reg     <= masked ? luma : pix_rd_reg[15:8];
            red_reg       <= masked ? luma : pix_rd_reg[7:0];
            frame_end_reg <= q_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg         <= DW'(1);
            fh_reg         <= DW'(1);
            fn_reg         <= CW'(1);
            t_reg          <= '0;
            wp_reg         <= '0;
            out_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dm_reg[1]      <= '0;
            dm_reg[2]      <= '0;
            dm_reg[3]      <= '0;
            dm_reg[4]      <= '0;
        end else begin
            if (adv) begin
                wp_reg <= wp_reg + PW'(1);
                if (first_item) begin
                    fw_reg    <= fw_clamp;
                    fh_reg    <= fh_clamp;
                    fn_reg    <= CW'(fw_clamp) * CW'(fh_clamp);
                    dm_reg[1] <= step - CW'(1);
                    dm_reg[2] <= (step << 1) - CW'(1);
                    dm_reg[3] <= (step << 1) + step - CW'(1);
                    dm_reg[4] <= (step << 2) - CW'(1);
                end
                if (out_active_reg && q_last) begin
                    t_reg          <= '0;
                    out_active_reg <= 1'b0;
                end else begin
                    t_reg <= t_reg + CW'(1);
                    if (!first_item && (t_reg == dm_reg[4])) begin
                        out_active_reg <= 1'b1;
                    end
                end
            end
            if (adv && out_active_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_blue_out  = blue_reg;
    assign m_green_out = green_reg;
    assign m_red_out   = red_reg;
    assign m_frame_end = frame_end_reg;

endmodule

`default_nettype wire

[rtl/core/rem_morph_stage.sv]
// One 3x3 cross erode or dilate stage of the mask pipeline with its line store.
// Depends on rem_pkg for sizes and the control bundle.
`default_nettype none

module rem_morph_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rem_pkg::rem_ctl_t           ctl,
    input  logic [rem_pkg::CNT_W-1:0]   start_prev,
    input  logic                        dilate,
    input  logic                        head_in,
    output logic                        mask_out,
    output logic [rem_pkg::COL_W-1:0]   col_out,
    output logic [rem_pkg::ROW_W-1:0]   row_out
);

    logic [1:0] line_mem [rem_pkg::LINE_DEPTH];

    logic [rem_pkg::LINE_PTR_W-1:0] wr_addr;
    logic [rem_pkg::LINE_PTR_W-1:0] addr_c;
    logic [rem_pkg::LINE_PTR_W-1:0] addr_r;
    logic [1:0] rdc_reg;
    logic       rdr_reg;
    logic [1:0] wd_reg;
    logic       bypc_reg;
    logic       bypr_reg;
    logic       left_reg;
    logic [rem_pkg::COL_W-1:0] col_reg;
    logic [rem_pkg::ROW_W-1:0] row_reg;

    logic [1:0] rd_c;
    logic [1:0] wdata;
    logic       center, up_v, right_v;
    logic       has_l, has_r, has_u, has_d;
    logic       col_last;

    assign wr_addr = ctl.wp[rem_pkg::LINE_PTR_W-1:0];
    assign addr_c  = ctl.wp_next[rem_pkg::LINE_PTR_W-1:0]
                   - ctl.fw_next[rem_pkg::LINE_PTR_W-1:0];
    assign addr_r  = addr_c + rem_pkg::LINE_PTR_W'(1);

    assign rd_c    = bypc_reg ? wd_reg : rdc_reg;
    assign center  = rd_c[1];
    assign up_v    = rd_c[0];
    assign right_v = bypr_reg ? wd_reg[1] : rdr_reg;
    assign wdata   = {head_in, center};

    assign has_l = (col_reg != '0);
    assign has_r = ((rem_pkg::DIM_W'(col_reg) + rem_pkg::DIM_W'(1)) < ctl.fw);
    assign has_u = (row_reg != '0);
    assign has_d = ((rem_pkg::DIM_W'(row_reg) + rem_pkg::DIM_W'(1)) < ctl.fh);
    assign col_last = (rem_pkg::DIM_W'(col_reg) == (ctl.fw - rem_pkg::DIM_W'(1)));

    always_comb begin
        if (dilate) begin
            mask_out = center | (has_l & left_reg) | (has_r & right_v)
                     | (has_u & up_v) | (has_d & head_in);
        end else begin
            mask_out = center & (!has_l | left_reg) & (!has_r | right_v)
                     & (!has_u | up_v) & (!has_d | head_in);
        end
    end

    assign col_out = col_reg;
    assign row_out = row_reg;

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            line_mem[wr_addr] <= wdata;
            left_reg          <= center;
        end
        rdc_reg  <= line_mem[addr_c];
        rdr_reg  <= line_mem[addr_r][1];
        wd_reg   <= wdata;
        bypc_reg <= ctl.adv && (addr_c == wr_addr);
        bypr_reg <= ctl.adv && (addr_r == wr_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (ctl.adv) begin
            if (ctl.t == start_prev) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (col_last) begin
                col_reg <= '0;
                row_reg <= row_reg + rem_pkg::ROW_W'(1);
            end else begin
                col_reg <= col_reg + rem_pkg::COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/rem_checker.sv]
// Port-level checks of the red-eye mask correction top level, bound to it below.
// Depends on red_eye_mask_correction_top_macros.svh.
`default_nettype none
`include "red_eye_mask_correction_top_macros.svh"

module rem_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [7:0]                   m_blue_out,
    input logic [7:0]                   m_green_out,
    input logic [7:0]                   m_red_out,
    input logic                         m_frame_end
);

    logic [24:0] m_payload;

    assign m_payload = {m_blue_out, m_green_out, m_red_out, m_frame_end};

    `REM_ASSERT_ALWAYS(a_reset_idle, !aresetn, !m_valid)
    `REM_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_payload))
    `REM_ASSERT_NOW(a_backpressure, !s_ready, m_valid && !m_ready)
    `REM_ASSERT_NOW(a_result_cause, $rose(m_valid), $past(s_valid && s_ready))

endmodule

bind red_eye_mask_correction_top rem_checker u_rem_checker (.*);

`default_nettype wire

[bench/tb_red_eye_mask_correction_top.sv]
// Self-checking testbench for red_eye_mask_correction_top: streams eye regions of random
// size and content, predicts every corrected pixel, and compares the results field by field.
// Depends on rem_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_red_eye_mask_correction_top;

    typedef struct {
        bit [7:0] b;
        bit [7:0] g;
        bit [7:0] r;
        bit       fe;
    } pixel_t;

    class red_eye_scoreboard;
        bit [6:0] reg_w = 64;
        bit [6:0] reg_h = 64;
        bit [5:0] win_xf = 0;
        bit [5:0] win_yf = 0;
        bit [5:0] win_xl = 63;
        bit [5:0] win_yl = 63;
        bit [7:0] red_min = 80;
        bit [7:0] pb[rem_pkg::MAX_WIDTH*rem_pkg::MAX_HEIGHT];
        bit [7:0] pg[rem_pkg::MAX_WIDTH*rem_pkg::MAX_HEIGHT];
        bit [7:0] pr[rem_pkg::MAX_WIDTH*rem_pkg::MAX_HEIGHT];
        bit mask[5][rem_pkg::MAX_WIDTH*rem_pkg::MAX_HEIGHT];
        int unsigned fw = 1, fh = 1, fn = 1, pos = 0;
        pixel_t corrected_q[$];
        int errors = 0;
        int results = 0;
        int masked_count = 0;

        function void set_reg(logic [2:0] idx, bit [31:0] v);
            case (idx)
                rem_pkg::REG_REGION_WIDTH: reg_w = v[6:0];
                rem_pkg::REG_REGION_HEIGHT: reg_h = v[6:0];
                rem_pkg::REG_WINDOW_X_FIRST: win_xf = v[5:0];
                rem_pkg::REG_WINDOW_Y_FIRST: win_yf = v[5:0];
                rem_pkg::REG_WINDOW_X_LAST: win_xl = v[5:0];
                rem_pkg::REG_WINDOW_Y_LAST: win_yl = v[5:0];
                rem_pkg::REG_RED_MINIMUM: red_min = v[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function bit morph(int k, int unsigned p, bit dil);
            int unsigned row, col;
            bit v;
            row = p / fw;
            col = p % fw;
            v = mask[k][p];
            if (col > 0) v = dil ? (v | mask[k][p-1]) : (v & mask[k][p-1]);
            if (col + 1 < fw) v = dil ? (v | mask[k][p+1]) : (v & mask[k][p+1]);
            if (row > 0) v = dil ? (v | mask[k][p-fw]) : (v & mask[k][p-fw]);
            if (row + 1 < fh) v = dil ? (v | mask[k][p+fw]) : (v & mask[k][p+fw]);
            return v;
        endfunction

        function void note_input(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fill);
            int unsigned t, d, lag, q, row, col, y;
            pixel_t e;
            if (pos == 0) begin
                fw = clamp_dim(32'(reg_w), rem_pkg::MAX_WIDTH);
                fh = clamp_dim(32'(reg_h), rem_pkg::MAX_HEIGHT);
                fn = fw * fh;
            end
            t = pos;
            if (t < fn) begin
                if (fill) return;
                pb[t] = b;
                pg[t] = g;
                pr[t] = r;
                mask[0][t] = (r > red_min) && (20 * r > 27 * g) && (20 * r > 27 * b);
            end
            for (int k = 1; k < 5; k++) begin
                d = k * (fw + 1);
                if (t >= d && t - d < fn) mask[k][t-d] = morph(k - 1, t - d, k == 2 || k == 3);
            end
            lag = 4 * (fw + 1);
            pos = t + 1;
            if (t < lag) return;
            if (t - lag >= fn) return;
            q = t - lag;
            row = q / fw;
            col = q % fw;
            e.b = pb[q];
            e.g = pg[q];
            e.r = pr[q];
            if (mask[4][q] && col >= win_xf && col <= win_xl && row >= win_yf && row <= win_yl)
            begin
                y = (1868 * e.b + 9617 * e.g + 4899 * e.r + 8192) >> 14;
                if (y > 255) y = 255;
                e.b = 8'(y);
                e.g = 8'(y);
                e.r = 8'(y);
                masked_count++;
            end
            e.fe = (q == fn - 1);
            corrected_q.insert(corrected_q.size(), e);
            if (q == fn - 1) pos = 0;
        endfunction

        function void check_result(pixel_t got);
            pixel_t e;
            results++;
            if (corrected_q.size() == 0) begin
                $display("%0t: unexpected result b=%0d g=%0d r=%0d end=%0d",
                         $time, got.b, got.g, got.r, got.fe);
                errors++;
                return;
            end
            e = corrected_q.pop_front();
            if (got.b != e.b) begin
                $display("%0t: blue expected %0d actual %0d", $time, e.b, got.b);
                errors++;
            end
            if (got.g != e.g) begin
                $display("%0t: green expected %0d actual %0d", $time, e.g, got.g);
                errors++;
            end
            if (got.r != e.r) begin
                $display("%0t: red expected %0d actual %0d", $time, e.r, got.r);
                errors++;
            end
            if (got.fe != e.fe) begin
                $display("%0t: frame_end expected %0d actual %0d", $time, e.fe, got.fe);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [rem_pkg::ADDR_W-1:0] paddr = '0;
    logic [rem_pkg::DATA_W-1:0] pwdata = '0;
    logic [rem_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_blue_in = '0;
    logic [7:0] s_green_in = '0;
    logic [7:0] s_red_in = '0;
    logic s_fill = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_blue_out;
    logic [7:0] m_green_out;
    logic [7:0] m_red_out;
    logic m_frame_end;

    red_eye_mask_correction_top i_dut (.*);

    red_eye_scoreboard sb = new();
    int sent_count = 0;
    int frame_count = 0;
    bit no_gaps = 1'b0;
    int idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int gap_len();
        int sel;
        if (no_gaps) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fill);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_blue_in <= b;
        s_green_in <= g;
        s_red_in <= r;
        s_fill <= fill;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b, g, r, fill);
        sent_count++;
    endtask

    task automatic apb_write(logic [2:0] idx, bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(bit [6:0] w, bit [6:0] h, bit [5:0] xf, bit [5:0] yf,
                             bit [5:0] xl, bit [5:0] yl, bit [7:0] rmin);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.corrected_q.size() != 0 || sb.pos != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        apb_write(rem_pkg::REG_REGION_WIDTH, 32'(w));
        apb_write(rem_pkg::REG_REGION_HEIGHT, 32'(h));
        apb_write(rem_pkg::REG_WINDOW_X_FIRST, 32'(xf));
        apb_write(rem_pkg::REG_WINDOW_Y_FIRST, 32'(yf));
        apb_write(rem_pkg::REG_WINDOW_X_LAST, 32'(xl));
        apb_write(rem_pkg::REG_WINDOW_Y_LAST, 32'(yl));
        apb_write(rem_pkg::REG_RED_MINIMUM, 32'(rmin));
    endtask

    task automatic run_frame();
        int unsigned w, h, bx0, bx1, by0, by1, rlo;
        bit [7:0] b, g, r;
        w = sb.clamp_dim(32'(sb.reg_w), rem_pkg::MAX_WIDTH);
        h = sb.clamp_dim(32'(sb.reg_h), rem_pkg::MAX_HEIGHT);
        bx0 = $urandom_range(0, w - 1);
        bx1 = $urandom_range(bx0, w - 1);
        by0 = $urandom_range(0, h - 1);
        by1 = $urandom_range(by0, h - 1);
        rlo = (sb.red_min == 255) ? 255 : sb.red_min + 1;
        for (int row = 0; row < h; row++) begin
            for (int col = 0; col < w; col++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
                if (col >= bx0 && col <= bx1 && row >= by0 && row <= by1
                    && $urandom_range(0, 9) != 0) begin
                    r = 8'($urandom_range(rlo, 255));
                    g = 8'($urandom_range(0, (20 * r - 1) / 27));
                    b = 8'($urandom_range(0, (20 * r - 1) / 27));
                end else if ($urandom_range(0, 19) == 0) begin
                    r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    b = $urandom_range(0, 1) ? 8'hff : 8'h00;
                end
                send_item(b, g, r, 1'b0);
            end
        end
        for (int i = 0; i < 4 * w + 4; i++)
            send_item(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0);
        frame_count++;
    endtask

    always @(posedge aclk) begin
        pixel_t got;
        if (aresetn && m_valid && m_ready) begin
            got.b = m_blue_out;
            got.g = m_green_out;
            got.r = m_red_out;
            got.fe = m_frame_end;
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int g;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sent_count > 300) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                held = 1'b1;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        int sel;
        bit [5:0] xf, yf, xl, yl;
        bit [6:0] w, h;
        bit [7:0] rmin;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero-sized region clamps to a single pixel.
        configure(0, 0, 0, 0, 63, 63, 80);
        no_gaps = 1'b1;
        send_item(8'h00, 8'h00, 8'hff, 1'b1);
        send_item(8'h00, 8'h00, 8'hff, 1'b0);
        send_item(8'hff, 8'hff, 8'hff, 1'b0);
        for (int i = 0; i < 7; i++) send_item(8'h00, 8'h00, 8'h00, 1'b1);
        no_gaps = 1'b0;
        frame_count++;

        configure(3, 2, 0, 0, 63, 63, 0);
        for (int i = 0; i < 3; i++) send_item(8'h00, 8'h00, 8'hff, 1'b0);
        send_item(8'hff, 8'hff, 8'hff, 1'b0);
        send_item(8'h00, 8'h00, 8'h01, 1'b0);
        send_item(8'h5e, 8'h5e, 8'h80, 1'b0);
        for (int i = 0; i < 16; i++) send_item(8'h00, 8'h00, 8'h00, 1'b1);
        frame_count++;

        while (sent_count < 450) begin
            sel = $urandom_range(0, 11);
            if (sel == 0) begin
                w = 127;
                h = 7'($urandom_range(1, 2));
            end else if (sel == 1) begin
                w = 7'($urandom_range(0, 1));
                h = 7'($urandom_range(0, 12));
            end else begin
                w = 7'($urandom_range(2, 10));
                h = 7'($urandom_range(1, 10));
            end
            sel = $urandom_range(0, 5);
            if (sel == 0) begin
                xf = 0; yf = 0; xl = 63; yl = 63;
            end else if (sel == 1) begin
                xf = 6'($urandom_range(1, 63)); xl = 6'(xf - 6'd1);
                yf = 6'($urandom_range(0, 8)); yl = 6'($urandom_range(0, 63));
            end else begin
                xf = 6'($urandom_range(0, 6)); xl = 6'($urandom_range(xf, 63));
                yf = 6'($urandom_range(0, 6)); yl = 6'($urandom_range(yf, 63));
            end
            sel = $urandom_range(0, 7);
            rmin = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(40, 150));
            no_gaps = ($urandom_range(0, 3) == 0);
            configure(w, h, xf, yf, xl, yl, rmin);
            run_frame();
        end

        // One region of the largest width, with the window in one corner.
        configure(64, 2, 40, 1, 63, 63, 80);
        no_gaps = 1'b0;
        run_frame();

        s_valid <= 1'b0;
        while (sb.corrected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d frames, %0d input transfers and %0d checked pixels,",
                 frame_count, sent_count, sb.results);
        $display("of which %0d were replaced by gray.", sb.masked_count);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
